@@ rtl/byte_round_cipher_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Byte round cipher assertion macros
// Shared concurrent assertion forms for the byte round cipher checkers.
// ----------------------------------------------------------------------------
`ifndef BYTE_ROUND_CIPHER_UNIT_DEFINES_SVH
`define BYTE_ROUND_CIPHER_UNIT_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define BRC_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define BRC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is checked through reset as well.
`define BRC_ASSERT_RESET(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/brc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte round cipher package
// Constants and types shared by the byte round cipher modules.
// ----------------------------------------------------------------------------
package brc_pkg;

   localparam int unsigned ROUNDS    = 4;
   localparam int unsigned KEY_BYTES = 16;
   localparam int unsigned POS_W     = $clog2(KEY_BYTES);
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   // Register indexes, taken from paddr[4:2].
   localparam logic [2:0] REG_KEY_WORD0 = 3'd0;
   localparam logic [2:0] REG_KEY_WORD1 = 3'd1;
   localparam logic [2:0] REG_KEY_WORD2 = 3'd2;
   localparam logic [2:0] REG_KEY_WORD3 = 3'd3;
   localparam logic [2:0] REG_DIRECTION = 3'd4;

   localparam logic [31:0] KEY_WORD0_RST = 32'h5E913CA7;
   localparam logic [31:0] KEY_WORD1_RST = 32'd200689874;
   localparam logic [31:0] KEY_WORD2_RST = 32'd1690184051;
   localparam logic [31:0] KEY_WORD3_RST = 32'd1334494488;

   localparam logic DIR_ENCRYPT = 1'b0;
   localparam logic DIR_DECRYPT = 1'b1;

   typedef struct packed {
      logic [KEY_BYTES-1:0][7:0] key;
      logic                      direction;
   } brc_cfg_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       last;
   } brc_result_type;

endpackage

@@ rtl/brc_csr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte round cipher register file
// Holds the 128-bit key and the direction bit behind an APB-style port.
// ----------------------------------------------------------------------------
module brc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [brc_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [brc_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [brc_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output brc_pkg::brc_cfg_type              cfg
);

   logic [3:0][31:0] key_word_ff;
   logic [3:0][31:0] key_word_in;
   logic             direction_ff;
   logic             direction_in;
   logic             wr_en;
   logic [2:0]       reg_index;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_index  = csr_paddr[4:2];

   always_comb begin
      key_word_in  = key_word_ff;
      direction_in = direction_ff;
      if (wr_en) begin
         unique case (reg_index)
            brc_pkg::REG_KEY_WORD0: key_word_in[0] = csr_pwdata;
            brc_pkg::REG_KEY_WORD1: key_word_in[1] = csr_pwdata;
            brc_pkg::REG_KEY_WORD2: key_word_in[2] = csr_pwdata;
            brc_pkg::REG_KEY_WORD3: key_word_in[3] = csr_pwdata;
            brc_pkg::REG_DIRECTION: direction_in   = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         brc_pkg::REG_KEY_WORD0: csr_prdata = key_word_ff[0];
         brc_pkg::REG_KEY_WORD1: csr_prdata = key_word_ff[1];
         brc_pkg::REG_KEY_WORD2: csr_prdata = key_word_ff[2];
         brc_pkg::REG_KEY_WORD3: csr_prdata = key_word_ff[3];
         brc_pkg::REG_DIRECTION: csr_prdata = {31'd0, direction_ff};
         default:                csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_word_ff[0] <= brc_pkg::KEY_WORD0_RST;
         key_word_ff[1] <= brc_pkg::KEY_WORD1_RST;
         key_word_ff[2] <= brc_pkg::KEY_WORD2_RST;
         key_word_ff[3] <= brc_pkg::KEY_WORD3_RST;
         direction_ff   <= brc_pkg::DIR_DECRYPT;
      end else begin
         key_word_ff  <= key_word_in;
         direction_ff <= direction_in;
      end
   end

   // Key byte k sits in bits 8k upward of the concatenated words.
   assign cfg.key       = {key_word_ff[3], key_word_ff[2], key_word_ff[1], key_word_ff[0]};
   assign cfg.direction = direction_ff;

endmodule

@@ rtl/brc_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte round cipher core
// Input register, message position counter and the unrolled cipher rounds.
// ----------------------------------------------------------------------------
module brc_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic [7:0]                 req_data_byte,
   input  logic                       req_last_byte,
   input  logic                       advance,
   input  brc_pkg::brc_cfg_type       cfg,
   output brc_pkg::brc_result_type    result
);

   logic                        valid_ff;
   logic                        valid_in;
   logic [7:0]                  data_ff;
   logic                        last_ff;
   logic [brc_pkg::POS_W-1:0]   pos_ff;
   logic [brc_pkg::POS_W-1:0]   pos_in;
   logic [brc_pkg::POS_W-1:0]   next_pos_ff;
   logic [brc_pkg::POS_W-1:0]   next_pos_in;
   logic                        accept;

   function automatic logic [7:0] encrypt_byte(
      input logic [7:0]                                 din,
      input logic [brc_pkg::KEY_BYTES-1:0][7:0]         key,
      input logic [brc_pkg::POS_W-1:0]                  pos
   );
      logic [7:0]                b;
      logic [brc_pkg::POS_W-1:0] idx;
      b = din;
      for (int r = 0; r < brc_pkg::ROUNDS; r++) begin
         idx = pos + brc_pkg::POS_W'(r * 3);
         b   = b ^ key[idx];
         b   = {b[4:0], b[7:5]};
         b   = b ^ 8'(r + 1);
         b   = b + key[pos];
      end
      return b;
   endfunction

   function automatic logic [7:0] decrypt_byte(
      input logic [7:0]                                 din,
      input logic [brc_pkg::KEY_BYTES-1:0][7:0]         key,
      input logic [brc_pkg::POS_W-1:0]                  pos
   );
      logic [7:0]                b;
      logic [brc_pkg::POS_W-1:0] idx;
      b = din;
      for (int r = brc_pkg::ROUNDS - 1; r >= 0; r--) begin
         idx = pos + brc_pkg::POS_W'(r * 3);
         b   = b - key[pos];
         b   = b ^ 8'(r + 1);
         b   = {b[2:0], b[7:3]};
         b   = b ^ key[idx];
      end
      return b;
   endfunction

   assign accept      = req_valid & advance;
   assign valid_in    = advance ? req_valid : valid_ff;
   assign pos_in      = next_pos_ff;
   // The position counter restarts after the last byte of a message.
   assign next_pos_in = accept ? (req_last_byte ? '0 : next_pos_ff + 1'b1) : next_pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         next_pos_ff <= '0;
      end else begin
         valid_ff    <= valid_in;
         next_pos_ff <= next_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= req_data_byte;
         last_ff <= req_last_byte;
         pos_ff  <= pos_in;
      end
   end

   always_comb begin
      result.valid = valid_ff;
      result.last  = last_ff;
      if (cfg.direction == brc_pkg::DIR_ENCRYPT) begin
         result.data = encrypt_byte(data_ff, cfg.key, pos_ff);
      end else begin
         result.data = decrypt_byte(data_ff, cfg.key, pos_ff);
      end
   end

endmodule

@@ rtl/byte_round_cipher_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte round cipher unit
// Keyed per-byte round cipher over a message stream, one result per byte.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Payload
//  req      in         req_valid/req_stall  req_data_byte, req_last_byte
//  rsp      out        rsp_valid/rsp_stall  rsp_out_byte, rsp_out_last
//  csr      in         APB-style, psel      paddr, pwdata, prdata
//
// One byte per cycle sustained while rsp is not stalled. A transfer on req reaches
// rsp through the input register ahead of the rounds and the result register after them.
// Synchronous reset empties both stages, zeroes the message position and
// reloads the key and direction registers with their defaults.
// A stall on rsp holds the result register; req stalls only when both stages are full.
// ----------------------------------------------------------------------------
module byte_round_cipher_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_data_byte,
   input  logic                            req_last_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [7:0]                      rsp_out_byte,
   output logic                            rsp_out_last,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [brc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [brc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [brc_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   brc_pkg::brc_cfg_type    cfg;
   brc_pkg::brc_result_type result;
   logic                    out_busy;
   logic                    advance;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [7:0]              rsp_byte_ff;
   logic                    rsp_last_ff;
   logic                    load_out;

   brc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   brc_core u_core (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .advance       (advance),
      .cfg           (cfg),
      .result        (result)
   );

   // The result register frees up whenever it is empty or its transfer completes.
   assign out_busy     = rsp_valid_ff & rsp_stall;
   assign advance      = ~result.valid | ~out_busy;
   assign req_stall    = ~advance;
   assign load_out     = ~out_busy & result.valid;
   assign rsp_valid_in = out_busy | result.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_byte_ff <= result.data;
         rsp_last_ff <= result.last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_out_last = rsp_last_ff;

endmodule

@@ rtl/brc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte round cipher checker
// Port-level assertions, bound to the byte round cipher unit.
// ----------------------------------------------------------------------------
`include "byte_round_cipher_unit_defines.svh"

module brc_assertions (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [7:0]                      rsp_out_byte,
   input logic                            rsp_out_last,
   input logic                            csr_pready
);

   // A stalled result holds its value until the transfer completes.
   `BRC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_out_byte) && $stable(rsp_out_last), "stalled result changed")

   // With the result register empty the input side can never be held off.
   `BRC_ASSERT_IMPL(a_no_stall_when_empty, !rsp_valid, !req_stall,
      "input stalled with empty output")

   // An input stall only ever comes from a stall on the result side.
   `BRC_ASSERT_IMPL(a_stall_source, req_stall, rsp_valid && rsp_stall,
      "input stall without output stall")

   // Reset leaves no result pending.
   `BRC_ASSERT_RESET(a_reset_empty, reset, !rsp_valid && csr_pready,
      "result pending after reset")

endmodule

bind byte_round_cipher_unit brc_assertions u_brc_assertions (
   .clock        (clock),
   .reset        (reset),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_out_byte (rsp_out_byte),
   .rsp_out_last (rsp_out_last),
   .csr_pready   (csr_pready)
);
